// File: rtl/core/console_line_editor_core_macros.svh
// assertion macros for the console line editor checker
`ifndef CONSOLE_LINE_EDITOR_CORE_MACROS_SVH
`define CONSOLE_LINE_EDITOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CLE_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("console line editor check failed");

// next-cycle implication, disabled while reset is high
`define CLE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("console line editor check failed");

`endif

// File: rtl/core/cle_pkg.sv
// shared constants and types for the console line editor
package cle_pkg;

  localparam int LINE_LENGTH = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_DEL = 8'h7F;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  // largest fill count a line may reach
  localparam logic [ADDR_W-1:0] FILL_CAP = ADDR_W'(LINE_LENGTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ECHO  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_MARK  = 4'b1000
  } state_t;

endpackage

// File: rtl/core/cle_ram.sv
// generic single-write, single-read ram with registered read data
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/console_line_editor_core.sv
// console line editor: line store, backspace handling, echo and line drain
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   input    | in_valid / in_stall    | byte_in
//   output   | out_valid / out_stall  | kind, value, last_of_run
//   config   | cfg_valid / cfg_ready  | echo_enable
//
// a byte is taken while in_stall is low; echoes (one or three) follow one per
// cycle unless the output stalls; a line end drains the line ram's bytes
// one per unstalled cycle via its single read port, then the newline marker
// reset clears the fill count and sets echo on; the line ram is not cleared
// in_stall is high while an earlier request still has results to hand out
// a stall on the output holds the result register and pauses the sequencer
module console_line_editor_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cle_pkg::BYTE_W-1:0] byte_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cle_pkg::KIND_W-1:0] kind,
  output logic [cle_pkg::BYTE_W-1:0] value,
  output logic                       last_of_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       echo_enable
);

  import cle_pkg::*;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0]  idx, idx_next;
  logic               data_ok, data_ok_next;
  logic [BYTE_W-1:0]  e_char, e_char_next;
  logic [1:0]         e_left, e_left_next;
  logic               e_erase, e_erase_next;
  logic               echo_on;

  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [BYTE_W-1:0]  emit_value;
  logic               emit_last;
  logic               out_free;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  logic               take;
  logic               is_print, is_erase, is_end;

  cle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_data (byte_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    is_print = byte_in inside {[PRINT_LO:PRINT_HI]};
    is_erase = (byte_in == BYTE_BS) || (byte_in == BYTE_DEL);
    is_end   = (byte_in == BYTE_CR) || ((byte_in == BYTE_LF) && (fill != '0));
  end

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    data_ok_next = data_ok;
    e_char_next  = e_char;
    e_left_next  = e_left;
    e_erase_next = e_erase;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx;
    emit         = 1'b0;
    emit_kind    = KIND_ECHO;
    emit_value   = '0;
    emit_last    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (take) begin
          if (is_end) begin
            idx_next = '0;
            if (fill == '0) begin
              state_next = ST_MARK;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              data_ok_next = 1'b1;
              state_next   = ST_DRAIN;
            end
          end else if (is_erase && (fill != '0)) begin
            fill_next = fill - 1'b1;
            if (echo_on) begin
              e_char_next  = BYTE_BS;
              e_left_next  = 2'd3;
              e_erase_next = 1'b1;
              state_next   = ST_ECHO;
            end
          end else if (is_print && (fill < FILL_CAP)) begin
            wr_en     = 1'b1;
            fill_next = fill + 1'b1;
            if (echo_on) begin
              e_char_next  = byte_in;
              e_left_next  = 2'd1;
              e_erase_next = 1'b0;
              state_next   = ST_ECHO;
            end
          end
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_ECHO;
          // erase sequence is backspace, space, backspace
          emit_value = (e_erase && (e_left == 2'd2)) ? BYTE_SP : e_char;
          emit_last  = (e_left == 2'd1);
          e_left_next = e_left - 1'b1;
          if (e_left == 2'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (data_ok && out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_LINE;
          emit_value = rd_data;
          idx_next   = idx + 1'b1;
          if (idx + 1'b1 == fill) begin
            data_ok_next = 1'b0;
            state_next   = ST_MARK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx + 1'b1;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_MARK;
          emit_value = '0;
          emit_last  = 1'b1;
          fill_next  = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      idx       <= '0;
      data_ok   <= 1'b0;
      e_left    <= '0;
      echo_on   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      idx     <= idx_next;
      data_ok <= data_ok_next;
      e_left  <= e_left_next;
      if (cfg_valid && cfg_ready) begin
        echo_on <= echo_enable;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_char  <= e_char_next;
    e_erase <= e_erase_next;
    if (emit) begin
      kind        <= emit_kind;
      value       <= emit_value;
      last_of_run <= emit_last;
    end
  end

endmodule

// File: rtl/core/cle_checker.sv
// port-level checks for the console line editor, bound to the top level
`include "console_line_editor_core_macros.svh"

module cle_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [cle_pkg::BYTE_W-1:0] byte_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [cle_pkg::KIND_W-1:0] kind,
  input logic [cle_pkg::BYTE_W-1:0] value,
  input logic                       last_of_run,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       echo_enable
);

  import cle_pkg::*;

  // a stalled result holds
  `CLE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind) && $stable(value) && $stable(last_of_run))

  // the newline marker carries zero and always closes the run
  `CLE_ASSERT_NOW(a_mark_form, clk, rst, out_valid && (kind == KIND_MARK), (value == '0) && last_of_run)

  // no result kind beyond the marker
  `CLE_ASSERT_NOW(a_kind_range, clk, rst, out_valid, (kind == KIND_ECHO) || (kind == KIND_LINE) || (kind == KIND_MARK))

  // mid-run the block keeps new requests out
  `CLE_ASSERT_NOW(a_busy_mid_run, clk, rst, out_valid && !last_of_run, in_stall)

endmodule

bind console_line_editor_core cle_checker u_cle_checker (.*);
